@@ design/sdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_pkg: shared types for the sorted descending table
// Command and status codes, the controller state type, and the packed item
// structures of the input and result channels.
// ----------------------------------------------------------------------------
package sdt_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;
    localparam int TOTAL_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HEAD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [TOTAL_W-1:0] entry_total;
    } out_item_t;

endpackage

@@ design/sdt_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_mem: entry storage
// Single-port-write, single-port-read synchronous memory with a registered
// read data output.
// ----------------------------------------------------------------------------
module sdt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/sorted_descending_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_descending_table: bounded table of signed values, greatest first
// Inserts, searches and clears a table held in one synchronous memory.
// ----------------------------------------------------------------------------
// The table takes one item at a time and returns one result item for each.
// A clear, a no-op, an insert into a full or empty table and a search of an
// empty table go straight to the result without a memory walk. An insert
// walks the memory from the tail toward the head, moving one entry down per
// cycle, until the value lands after a stored entry that is not smaller or,
// when every entry is smaller, at the head. A search walks from the head
// and stops at the first equal entry, at the first smaller one or at the
// end of the table. The single memory read port limits each walk to one
// entry per cycle. A new item is taken as soon as the previous one has
// reached the result register, even while that result still waits for the
// consumer.
// ----------------------------------------------------------------------------
module sorted_descending_table #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sdt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sdt_pkg::out_item_t m_item
);
    import sdt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Control and working registers.
    state_t                        state_reg, state_next;
    cmd_t                          cmd_reg, cmd_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 count_reg, count_next;
    status_t                       res_status_reg, res_status_next;
    logic [AW-1:0]                 res_pos_reg, res_pos_next;
    logic                          m_valid_reg, m_valid_next;
    out_item_t                     m_item_reg, m_item_next;

    // Memory access.
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic signed [VALUE_WIDTH-1:0] entry;
    logic signed [VALUE_WIDTH-1:0] in_key;
    logic                   accept;
    logic                   out_free;

    sdt_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign entry    = $signed(rd_data);
    assign in_key   = VALUE_WIDTH'(s_item.value);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_item_reg     <= m_item_next;
    end

    // Next state, memory control and result.
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = key_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next        = cmd_t'(s_item.command);
                    key_next        = in_key;
                    res_status_next = STAT_OK;
                    res_pos_next    = '0;
                    state_next      = ST_DONE;
                    unique case (cmd_t'(s_item.command))
                        CMD_INSERT: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                res_status_next = STAT_FULL;
                            end else if (count_reg == '0) begin
                                // Empty table: the value becomes the head.
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = in_key;
                                count_next = CW'(1);
                            end else begin
                                // Walk back from the tail.
                                idx_next   = AW'(count_reg - CW'(1));
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_reg - CW'(1));
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_SEARCH: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_MISS;
                            end else begin
                                idx_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (cmd_reg == CMD_INSERT) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg + AW'(1));
                    if (entry >= key_reg) begin
                        // The new value goes right after this entry.
                        wr_data      = key_reg;
                        res_pos_next = AW'(idx_reg + AW'(1));
                        count_next   = CW'(count_reg + CW'(1));
                        state_next   = ST_DONE;
                    end else begin
                        // Move this entry one place toward the tail.
                        wr_data = rd_data;
                        if (idx_reg == '0) begin
                            state_next = ST_HEAD;
                        end else begin
                            idx_next = AW'(idx_reg - AW'(1));
                            rd_en    = 1'b1;
                            rd_addr  = AW'(idx_reg - AW'(1));
                        end
                    end
                end else begin
                    if (entry == key_reg) begin
                        res_pos_next = idx_reg;
                        state_next   = ST_DONE;
                    end else if ((CW'(idx_reg) + CW'(1) == count_reg) || (entry < key_reg)) begin
                        // End of table, or past where an equal value could be.
                        res_status_next = STAT_MISS;
                        state_next      = ST_DONE;
                    end else begin
                        idx_next = AW'(idx_reg + AW'(1));
                        rd_en    = 1'b1;
                        rd_addr  = AW'(idx_reg + AW'(1));
                    end
                end
            end

            ST_HEAD: begin
                // Every entry was smaller: the value takes the head.
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data      = key_reg;
                res_pos_next = '0;
                count_next   = CW'(count_reg + CW'(1));
                state_next   = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_item_next.status      = res_status_reg;
                    m_item_next.position    = POS_W'(res_pos_reg);
                    m_item_next.entry_total = TOTAL_W'(count_reg);
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Only stored entries are ever read.
    a_read_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (CW'(rd_addr) < count_reg))
        else $error("read of an entry beyond the count");

    // A full status is reported only when the table is full.
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_status_reg == STAT_FULL) |-> count_reg == CW'(CAPACITY))
        else $error("full status with room left");

    // An insert walk only runs with room for one more entry.
    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && cmd_reg == CMD_INSERT) |-> count_reg < CW'(CAPACITY))
        else $error("insert walk in a full table");

endmodule

@@ tb/sorted_descending_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_descending_table_tb: self-checking bench for the sorted table
// A directed opening covers the empty table, the value extremes, duplicates,
// the full-table drop, clear and the unused command. A long random run of
// insert, search and clear bursts follows. Every accepted item is applied to
// a local copy of the table, and each result item is checked in order.
// ----------------------------------------------------------------------------
module sorted_descending_table_tb;

    import sdt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_CYCLES = 40;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Local copy of the table, head first, and the expected result items.
    logic signed [VALUE_W-1:0] table_entries [TABLE_DEPTH];
    int                        entry_count = 0;
    out_item_t                 expected_results[$];
    out_item_t                 oldest;

    int error_count = 0;
    int cycle_count = 0;
    int send_gap_max = 6;
    int sink_stall_max = 6;

    sorted_descending_table #(
        .CAPACITY    (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Clock with a 2 ns period.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Cycle counter and watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Applies one accepted item to the local table and returns its result.
    function automatic out_item_t apply_table_op(input in_item_t item);
        out_item_t                 res;
        logic signed [VALUE_W-1:0] key;
        int                        slot;
        bit                        hit;
        key = item.value;
        res = '0;
        slot = 0;
        hit = 1'b0;
        case (cmd_t'(item.command))
            CMD_INSERT: begin
                if (entry_count >= TABLE_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    // The new value goes after every entry that is not smaller.
                    for (int i = 0; i < entry_count; i++) begin
                        if (table_entries[i] >= key) slot = i + 1;
                    end
                    for (int i = entry_count; i > slot; i--) begin
                        table_entries[i] = table_entries[i - 1];
                    end
                    table_entries[slot] = key;
                    entry_count++;
                    res.status = STAT_OK;
                    res.position = slot[POS_W-1:0];
                end
            end
            CMD_SEARCH: begin
                for (int i = 0; i < entry_count; i++) begin
                    if (!hit && table_entries[i] == key) begin
                        hit = 1'b1;
                        slot = i;
                    end
                end
                res.status = hit ? STAT_OK : STAT_MISS;
                res.position = hit ? slot[POS_W-1:0] : '0;
            end
            CMD_CLEAR: begin
                entry_count = 0;
                res.status = STAT_OK;
            end
            default: begin
                res.status = STAT_OK;
            end
        endcase
        res.entry_total = entry_count[TOTAL_W-1:0];
        return res;
    endfunction

    // Sends one item; called at a falling edge and returns at a falling edge.
    task automatic send_item(input cmd_t cmd, input logic signed [VALUE_W-1:0] value);
        in_item_t item;
        int       gap;
        item.command = cmd;
        item.value = value;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= item;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_table_op(item));
        @(negedge aclk);
    endtask

    // Holds the input idle until every outstanding result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // Result consumer: stalls a random number of cycles before each item.
    initial begin : result_sink
        int stall;
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result item arrived with none expected");
            end else begin
                oldest = expected_results.pop_front();
                if (m_item.status !== oldest.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_item.status, oldest.status));
                if (m_item.position !== oldest.position)
                    report_mismatch($sformatf("position got %0d want %0d",
                                              m_item.position, oldest.position));
                if (m_item.entry_total !== oldest.entry_total)
                    report_mismatch($sformatf("entry_total got %0d want %0d",
                                              m_item.entry_total, oldest.entry_total));
            end
        end
    end

    // Value styles: a narrow band full of duplicates, full range, or extremes.
    function automatic logic signed [VALUE_W-1:0] draw_value(input int style);
        int pick;
        case (style)
            0: begin
                pick = int'($urandom_range(0, 8)) - 4;
                return pick;
            end
            1: return $urandom();
            default: begin
                case ($urandom_range(0, 5))
                    0: return VALUE_MAX;
                    1: return VALUE_MIN;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    // Searches mostly aim at stored entries so that hits are common.
    function automatic logic signed [VALUE_W-1:0] draw_search_value(input int style);
        if (entry_count > 0 && $urandom_range(0, 99) < 60)
            return table_entries[$urandom_range(0, entry_count - 1)];
        return draw_value(style);
    endfunction

    // An empty table misses every search, and the unused command changes nothing.
    task automatic test_empty_table();
        send_item(CMD_SEARCH, 0);
        send_item(CMD_NOP, VALUE_MAX);
    endtask

    // Extremes and duplicates: a duplicate lands after its equal entries.
    task automatic test_extremes();
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, VALUE_MAX);
        send_item(CMD_INSERT, VALUE_MIN);
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, -1);
        send_item(CMD_SEARCH, VALUE_MAX);
        send_item(CMD_SEARCH, VALUE_MIN);
        send_item(CMD_SEARCH, 0);
        send_item(CMD_SEARCH, 1);
    endtask

    // Fill the table, then an insert into the full table is dropped.
    task automatic test_full_table();
        for (int k = 0; k < TABLE_DEPTH - 5; k++) begin
            send_item(CMD_INSERT, k * 3 - 15);
        end
        send_item(CMD_INSERT, 42);
        send_item(CMD_SEARCH, table_entries[TABLE_DEPTH - 1]);
    endtask

    // Clear after the pipeline has fully drained, then check the empty count.
    task automatic test_clear();
        drain_results();
        send_item(CMD_CLEAR, VALUE_MIN);
        send_item(CMD_NOP, 0);
    endtask

    // Random bursts with varied insert rate, value style and idling.
    task automatic test_random();
        int sent;
        int style;
        int insert_pct;
        int span;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            style = $urandom_range(0, 2);
            insert_pct = 30 + 20 * $urandom_range(0, 2);
            span = $urandom_range(10, 40);
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            for (int k = 0; k < span; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < insert_pct)
                    send_item(CMD_INSERT, draw_value(style));
                else if (pick < 94)
                    send_item(CMD_SEARCH, draw_search_value(style));
                else if (pick < 97)
                    send_item(CMD_NOP, $urandom());
                else
                    send_item(CMD_CLEAR, $urandom());
            end
            sent += span;
            if ($urandom_range(0, 1) == 1) begin
                send_item(CMD_CLEAR, $urandom());
                sent++;
            end
            if ($urandom_range(0, 7) == 0) drain_results();
        end
    endtask

    // Main sequence.
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_empty_table();
        test_extremes();
        test_full_table();
        test_clear();
        test_random();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
